>>> sv/rbpg_pkg.sv
// shared types, constants and color helpers for the rainbow bar pattern generator
`default_nettype none

package rbpg_pkg;

    localparam int MAX_DIM_DEF   = 4096;
    localparam int CFG_W         = 13;
    localparam int POS_W         = 12;
    localparam int COLOR_W       = 24;
    localparam int CFG_IDX_W     = 2;
    localparam int DEFAULT_BANDS = 8;
    localparam int RAMP_SHIFT    = 8;

    localparam logic [CFG_W-1:0]   RST_FRAME_WIDTH  = 13'd1280;
    localparam logic [CFG_W-1:0]   RST_FRAME_HEIGHT = 13'd720;
    localparam logic [CFG_W-1:0]   RST_BAND_COUNT   = 13'd8;
    localparam logic [COLOR_W-1:0] COLOR_RED        = 24'hFF0000;

    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_FRAME_WIDTH  = 2'd0,
        CFG_FRAME_HEIGHT = 2'd1,
        CFG_BAND_COUNT   = 2'd2,
        CFG_COLOR_FORMAT = 2'd3
    } t_cfg_idx;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_DIV_ROWS,
        ST_DIV_BANDS,
        ST_EMIT,
        ST_DIV_SECTOR,
        ST_DIV_RAMP
    } t_state;

    typedef enum logic [2:0] {
        SEC_RED_YELLOW   = 3'd0,
        SEC_YELLOW_GREEN = 3'd1,
        SEC_GREEN_CYAN   = 3'd2,
        SEC_CYAN_BLUE    = 3'd3,
        SEC_BLUE_MAGENTA = 3'd4,
        SEC_MAGENTA_RED  = 3'd5,
        SEC_WRAP         = 3'd6,
        SEC_UNUSED       = 3'd7
    } t_sector;

    function automatic logic [COLOR_W-1:0] hue_rgb(input t_sector sec,
                                                   input logic [7:0] rise,
                                                   input logic [7:0] fall);
        logic [COLOR_W-1:0] rgb;
        case (sec)
            SEC_RED_YELLOW:   rgb = {8'hFF, rise, 8'h00};
            SEC_YELLOW_GREEN: rgb = {fall, 8'hFF, 8'h00};
            SEC_GREEN_CYAN:   rgb = {8'h00, 8'hFF, rise};
            SEC_CYAN_BLUE:    rgb = {8'h00, fall, 8'hFF};
            SEC_BLUE_MAGENTA: rgb = {rise, 8'h00, 8'hFF};
            SEC_MAGENTA_RED:  rgb = {8'hFF, 8'h00, fall};
            default:          rgb = COLOR_RED;
        endcase
        return rgb;
    endfunction

    function automatic logic [COLOR_W-1:0] to_pixel(input logic [COLOR_W-1:0] rgb,
                                                    input logic fmt_888);
        logic [COLOR_W-1:0] pix;
        if (fmt_888) begin
            pix = rgb;
        end else begin
            pix = {8'h00, rgb[23:19], rgb[15:10], rgb[7:3]};
        end
        return pix;
    endfunction

endpackage

`default_nettype wire

>>> sv/rbpg_div.sv
// iterative restoring divider, one quotient bit per cycle
`default_nettype none

module rbpg_div #(
    parameter int DVD_W = 21,
    parameter int DSR_W = 13
) (
    input  wire logic             i_clk,
    input  wire logic             i_rst_n,
    input  wire logic             i_start,
    input  wire logic [DVD_W-1:0] i_dividend,
    input  wire logic [DSR_W-1:0] i_divisor,
    output logic                  o_done,
    output logic [DVD_W-1:0]      o_quot,
    output logic [DSR_W-1:0]      o_rem
);

    localparam int CNT_W = $clog2(DVD_W + 1);

    logic             r_busy,  n_busy;
    logic             r_done,  n_done;
    logic [CNT_W-1:0] r_cnt,   n_cnt;
    logic [DVD_W-1:0] r_quot,  n_quot;
    logic [DSR_W-1:0] r_rem,   n_rem;
    logic [DSR_W-1:0] r_dsr,   n_dsr;

    logic [DSR_W:0]   shifted;
    logic [DSR_W:0]   diff;
    logic             ge;

    always_comb begin
        shifted = {r_rem, r_quot[DVD_W-1]};
        diff    = shifted - {1'b0, r_dsr};
        ge      = shifted >= {1'b0, r_dsr};
        n_busy  = r_busy;
        n_done  = 1'b0;
        n_cnt   = r_cnt;
        n_quot  = r_quot;
        n_rem   = r_rem;
        n_dsr   = r_dsr;
        if (i_start) begin
            n_busy = 1'b1;
            n_cnt  = CNT_W'(DVD_W);
            n_quot = i_dividend;
            n_rem  = '0;
            n_dsr  = i_divisor;
        end else if (r_busy) begin
            n_quot = {r_quot[DVD_W-2:0], ge};
            n_rem  = ge ? diff[DSR_W-1:0] : shifted[DSR_W-1:0];
            n_cnt  = r_cnt - 1'b1;
            if (r_cnt == CNT_W'(1)) begin
                n_busy = 1'b0;
                n_done = 1'b1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_cnt  <= '0;
        end else begin
            r_busy <= n_busy;
            r_done <= n_done;
            r_cnt  <= n_cnt;
        end
        r_quot <= n_quot;
        r_rem  <= n_rem;
        r_dsr  <= n_dsr;
    end

    assign o_done = r_done;
    assign o_quot = r_quot;
    assign o_rem  = r_rem;

endmodule

`default_nettype wire

>>> sv/rainbow_bar_pattern_generator_top.sv
// top level of the rainbow bar pattern generator: sequencer, counters, config and output register
// an ordinary pixel goes from idle to emit, which loads the output register once it is free
// the first pixel of a frame first runs the divider twice, for band rows and band count
// a pixel ending a band with more to follow runs two more divisions after its output
// all divisions share one bit-serial divider; input is taken only in the idle state
// synchronous active-low reset clears counters, sequencer, output valid and config to defaults
`default_nettype none

module rainbow_bar_pattern_generator_top
    import rbpg_pkg::*;
#(
    parameter int MAX_DIM = MAX_DIM_DEF
) (
    input  wire logic                 i_clk,
    input  wire logic                 i_rst_n,
    input  wire logic                 s_axis_tvalid,
    output logic                      s_axis_tready,
    input  wire logic [7:0]           s_axis_tdata,   // [0] restart
    output logic                      m_axis_tvalid,
    input  wire logic                 m_axis_tready,
    output logic [47:0]               m_axis_tdata,   // [23:0] pixel, [35:24] column, [47:36] row
    output logic                      m_axis_tlast,   // end_of_frame
    output logic                      m_axis_tuser,   // [0] end_of_row
    input  wire logic                 i_cfg_valid,
    output logic                      o_cfg_ready,
    input  wire logic [CFG_IDX_W-1:0] i_cfg_index,
    input  wire logic [CFG_W-1:0]     i_cfg_data
);

    localparam int DIM_W = $clog2(MAX_DIM + 1);
    localparam int CNT_W = $clog2(MAX_DIM);
    localparam int EXT_W = (DIM_W > CFG_W) ? DIM_W : CFG_W;
    localparam int DVD_W = DIM_W + RAMP_SHIFT;

    // configuration registers
    logic [CFG_W-1:0]   r_frame_width;
    logic [CFG_W-1:0]   r_frame_height;
    logic [CFG_W-1:0]   r_band_count;
    logic               r_color_format;

    // sequencer and frame state
    t_state             r_state, n_state;
    logic [CNT_W-1:0]   r_col, n_col;
    logic [CNT_W-1:0]   r_row, n_row;
    logic [CNT_W-1:0]   r_band_idx, n_band_idx;
    logic [CNT_W-1:0]   r_rib, n_rib;
    logic [DIM_W-1:0]   r_band_rows, n_band_rows;
    logic [DIM_W-1:0]   r_bands_total, n_bands_total;
    logic [COLOR_W-1:0] r_color, n_color;
    t_sector            r_sector, n_sector;

    // output register
    logic               r_out_valid, n_out_valid;
    logic [COLOR_W-1:0] r_out_pix, n_out_pix;
    logic [POS_W-1:0]   r_out_col, n_out_col;
    logic [POS_W-1:0]   r_out_row, n_out_row;
    logic               r_out_eor, n_out_eor;
    logic               r_out_eof, n_out_eof;

    // divider
    logic               div_start;
    logic [DVD_W-1:0]   div_dividend;
    logic [DIM_W-1:0]   div_divisor;
    logic               div_done;
    logic [DVD_W-1:0]   div_quot;
    logic [DIM_W-1:0]   div_rem;

    logic               s_xfer;
    logic               out_free;
    logic               frame_start;
    logic [DIM_W-1:0]   w_eff;
    logic [DIM_W-1:0]   h_eff;
    logic [EXT_W-1:0]   bands_req;
    logic [DIM_W-1:0]   segs;
    logic               eor;
    logic               eof;
    logic [DIM_W-1:0]   rib_inc;
    logic               band_wrap;
    logic               advance;
    logic [CNT_W-1:0]   next_idx;
    logic [DVD_W-1:0]   next_idx_ext;
    logic [DVD_W-1:0]   rem_ext;
    logic [7:0]         rise;
    logic [7:0]         fall;

    function automatic logic [DIM_W-1:0] eff_dim(input logic [CFG_W-1:0] v);
        logic [EXT_W-1:0] ext;
        logic [DIM_W-1:0] res;
        ext = EXT_W'(v);
        if (ext == '0) begin
            res = DIM_W'(1);
        end else if (ext > EXT_W'(MAX_DIM)) begin
            res = DIM_W'(MAX_DIM);
        end else begin
            res = DIM_W'(ext);
        end
        return res;
    endfunction

    rbpg_div #(
        .DVD_W (DVD_W),
        .DSR_W (DIM_W)
    ) u_div (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_start    (div_start),
        .i_dividend (div_dividend),
        .i_divisor  (div_divisor),
        .o_done     (div_done),
        .o_quot     (div_quot),
        .o_rem      (div_rem)
    );

    // configuration writes
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_frame_width  <= RST_FRAME_WIDTH;
            r_frame_height <= RST_FRAME_HEIGHT;
            r_band_count   <= RST_BAND_COUNT;
            r_color_format <= 1'b0;
        end else if (i_cfg_valid) begin
            case (t_cfg_idx'(i_cfg_index))
                CFG_FRAME_WIDTH:  r_frame_width  <= i_cfg_data;
                CFG_FRAME_HEIGHT: r_frame_height <= i_cfg_data;
                CFG_BAND_COUNT:   r_band_count   <= i_cfg_data;
                CFG_COLOR_FORMAT: r_color_format <= i_cfg_data[0];
                default: begin
                end
            endcase
        end
    end

    assign o_cfg_ready = 1'b1;

    // frame geometry and band bookkeeping
    always_comb begin
        s_xfer       = s_axis_tvalid && s_axis_tready;
        out_free     = !r_out_valid || m_axis_tready;
        frame_start  = s_axis_tdata[0] || ((r_col == '0) && (r_row == '0));
        w_eff        = eff_dim(r_frame_width);
        h_eff        = eff_dim(r_frame_height);
        bands_req    = (r_band_count == '0) ? EXT_W'(DEFAULT_BANDS) : EXT_W'(r_band_count);
        segs         = (bands_req > EXT_W'(h_eff)) ? h_eff : DIM_W'(bands_req);
        eor          = DIM_W'(r_col) >= (w_eff - 1'b1);
        eof          = eor && (DIM_W'(r_row) >= (h_eff - 1'b1));
        rib_inc      = DIM_W'(r_rib) + 1'b1;
        band_wrap    = rib_inc >= r_band_rows;
        advance      = eor && !eof && band_wrap && ((DIM_W'(r_band_idx) + 1'b1) < r_bands_total);
        next_idx     = r_band_idx + 1'b1;
        next_idx_ext = DVD_W'(next_idx);
        rem_ext      = DVD_W'(div_rem);
        rise         = div_quot[7:0];
        fall         = 8'hFF - rise - {7'd0, (div_rem != '0)};
    end

    // next state
    always_comb begin
        n_state = r_state;
        case (r_state)
            ST_IDLE: begin
                if (s_xfer) begin
                    n_state = frame_start ? ST_DIV_ROWS : ST_EMIT;
                end
            end
            ST_DIV_ROWS: begin
                if (div_done) begin
                    n_state = ST_DIV_BANDS;
                end
            end
            ST_DIV_BANDS: begin
                if (div_done) begin
                    n_state = ST_EMIT;
                end
            end
            ST_EMIT: begin
                if (out_free) begin
                    n_state = advance ? ST_DIV_SECTOR : ST_IDLE;
                end
            end
            ST_DIV_SECTOR: begin
                if (div_done) begin
                    n_state = ST_DIV_RAMP;
                end
            end
            ST_DIV_RAMP: begin
                if (div_done) begin
                    n_state = ST_IDLE;
                end
            end
            default: n_state = ST_IDLE;
        endcase
    end

    // sequencer outputs: handshake and divider operands
    always_comb begin
        s_axis_tready = 1'b0;
        div_start     = 1'b0;
        div_dividend  = '0;
        div_divisor   = DIM_W'(1);
        case (r_state)
            ST_IDLE: begin
                s_axis_tready = 1'b1;
                div_start     = s_xfer && frame_start;
                div_dividend  = DVD_W'(h_eff);
                div_divisor   = segs;
            end
            ST_DIV_ROWS: begin
                // ceil(height / band_rows)
                div_start    = div_done;
                div_dividend = DVD_W'(h_eff) + div_quot - 1'b1;
                div_divisor  = div_quot[DIM_W-1:0];
            end
            ST_EMIT: begin
                // sector and remainder of 6k over bands-1
                div_start    = out_free && advance;
                div_dividend = (next_idx_ext << 2) + (next_idx_ext << 1);
                div_divisor  = r_bands_total - 1'b1;
            end
            ST_DIV_SECTOR: begin
                // 255 * remainder over bands-1
                div_start    = div_done;
                div_dividend = (rem_ext << RAMP_SHIFT) - rem_ext;
                div_divisor  = r_bands_total - 1'b1;
            end
            default: begin
            end
        endcase
    end

    // datapath next values
    always_comb begin
        n_col         = r_col;
        n_row         = r_row;
        n_band_idx    = r_band_idx;
        n_rib         = r_rib;
        n_band_rows   = r_band_rows;
        n_bands_total = r_bands_total;
        n_color       = r_color;
        n_sector      = r_sector;
        n_out_valid   = r_out_valid && !m_axis_tready;
        n_out_pix     = r_out_pix;
        n_out_col     = r_out_col;
        n_out_row     = r_out_row;
        n_out_eor     = r_out_eor;
        n_out_eof     = r_out_eof;
        case (r_state)
            ST_IDLE: begin
                if (s_xfer) begin
                    if (s_axis_tdata[0]) begin
                        n_col = '0;
                        n_row = '0;
                    end
                    if (frame_start) begin
                        n_band_idx = '0;
                        n_rib      = '0;
                        n_color    = COLOR_RED;
                    end
                end
            end
            ST_DIV_ROWS: begin
                if (div_done) begin
                    n_band_rows = div_quot[DIM_W-1:0];
                end
            end
            ST_DIV_BANDS: begin
                if (div_done) begin
                    n_bands_total = div_quot[DIM_W-1:0];
                end
            end
            ST_EMIT: begin
                if (out_free) begin
                    n_out_valid = 1'b1;
                    n_out_pix   = to_pixel(r_color, r_color_format);
                    n_out_col   = POS_W'(r_col);
                    n_out_row   = POS_W'(r_row);
                    n_out_eor   = eor;
                    n_out_eof   = eof;
                    if (!eor) begin
                        n_col = r_col + 1'b1;
                    end else begin
                        n_col = '0;
                        if (eof) begin
                            n_row = '0;
                        end else begin
                            n_row = r_row + 1'b1;
                            n_rib = band_wrap ? '0 : CNT_W'(rib_inc);
                            if (advance) begin
                                n_band_idx = next_idx;
                            end
                        end
                    end
                end
            end
            ST_DIV_SECTOR: begin
                if (div_done) begin
                    n_sector = t_sector'(div_quot[2:0]);
                end
            end
            ST_DIV_RAMP: begin
                if (div_done) begin
                    n_color = hue_rgb(r_sector, rise, fall);
                end
            end
            default: begin
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state       <= ST_IDLE;
            r_col         <= '0;
            r_row         <= '0;
            r_band_idx    <= '0;
            r_rib         <= '0;
            r_band_rows   <= DIM_W'(1);
            r_bands_total <= DIM_W'(1);
            r_color       <= COLOR_RED;
            r_sector      <= SEC_WRAP;
            r_out_valid   <= 1'b0;
        end else begin
            r_state       <= n_state;
            r_col         <= n_col;
            r_row         <= n_row;
            r_band_idx    <= n_band_idx;
            r_rib         <= n_rib;
            r_band_rows   <= n_band_rows;
            r_bands_total <= n_bands_total;
            r_color       <= n_color;
            r_sector      <= n_sector;
            r_out_valid   <= n_out_valid;
        end
        r_out_pix <= n_out_pix;
        r_out_col <= n_out_col;
        r_out_row <= n_out_row;
        r_out_eor <= n_out_eor;
        r_out_eof <= n_out_eof;
    end

    assign m_axis_tvalid = r_out_valid;
    assign m_axis_tdata  = {r_out_row, r_out_col, r_out_pix};
    assign m_axis_tlast  = r_out_eof;
    assign m_axis_tuser  = r_out_eor;

endmodule

`default_nettype wire

>>> sv/rbpg_checker.sv
// port-level checks for the rainbow bar pattern generator, bound to the top level
`default_nettype none

module rbpg_checker (
    input wire logic        i_clk,
    input wire logic        i_rst_n,
    input wire logic        s_axis_tvalid,
    input wire logic        s_axis_tready,
    input wire logic        m_axis_tvalid,
    input wire logic        m_axis_tready,
    input wire logic [47:0] m_axis_tdata,
    input wire logic        m_axis_tlast,
    input wire logic        m_axis_tuser
);

    // end of frame is always also end of row
    a_eof_is_eor: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tvalid && m_axis_tlast |-> m_axis_tuser)
        else $error("end of frame without end of row");

    // sequencer is busy in the cycle after an input transfer
    a_busy_after_xfer: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        s_axis_tvalid && s_axis_tready |=> !s_axis_tready)
        else $error("input ready right after a transfer");

    // reset empties the output register and returns to idle
    a_reset_state: assert property (@(posedge i_clk)
        !i_rst_n |=> !m_axis_tvalid && s_axis_tready)
        else $error("bad state after reset");

    // stalled output holds
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tvalid && !m_axis_tready |=>
            m_axis_tvalid && $stable(m_axis_tdata) && $stable(m_axis_tlast)
            && $stable(m_axis_tuser))
        else $error("stalled output changed");

endmodule

bind rainbow_bar_pattern_generator_top rbpg_checker u_rbpg_checker (.*);

`default_nettype wire

>>> tb/sv/tb_rainbow_bar_pattern_generator_top.sv
// self-checking testbench for the rainbow bar pattern generator top level
module tb_rainbow_bar_pattern_generator_top
    import rbpg_pkg::*;
();

    timeunit 1ns;
    timeprecision 1ps;

    localparam int unsigned CYCLE_LIMIT  = 5_000_000;
    localparam int unsigned RANDOM_TICKS = 900;
    localparam int unsigned SCAN_TICKS   = 128;
    localparam int unsigned SETTLE_WAIT  = 64;

    typedef struct {
        logic [COLOR_W-1:0] pixel;
        logic [POS_W-1:0]   column;
        logic [POS_W-1:0]   row;
        logic               eor;
        logic               eof;
    } t_pixel;

    logic                 i_clk = 1'b0;
    logic                 i_rst_n = 1'b0;
    logic                 s_axis_tvalid = 1'b0;
    logic                 s_axis_tready;
    logic [7:0]           s_axis_tdata = '0;     // [0] restart
    logic                 m_axis_tvalid;
    logic                 m_axis_tready = 1'b0;
    logic [47:0]          m_axis_tdata;          // [23:0] pixel, [35:24] column, [47:36] row
    logic                 m_axis_tlast;          // end_of_frame
    logic                 m_axis_tuser;          // [0] end_of_row
    logic                 i_cfg_valid = 1'b0;
    logic                 o_cfg_ready;
    t_cfg_idx             i_cfg_index = CFG_FRAME_WIDTH;
    logic [CFG_W-1:0]     i_cfg_data = '0;

    // register image
    logic [CFG_W-1:0] cfg_width  = RST_FRAME_WIDTH;
    logic [CFG_W-1:0] cfg_height = RST_FRAME_HEIGHT;
    logic [CFG_W-1:0] cfg_bands  = RST_BAND_COUNT;
    logic             cfg_rgb888 = 1'b0;

    // pattern state
    int unsigned        pos_x = 0;
    int unsigned        pos_y = 0;
    int unsigned        band_idx = 0;
    int unsigned        band_row = 0;
    int unsigned        rows_per_band = 1;
    int unsigned        band_total = 1;
    logic [COLOR_W-1:0] band_rgb = COLOR_RED;

    logic   ticks_todo[$];
    t_pixel pixels_due[$];
    t_pixel due;
    int unsigned ticks_queued = 0;
    int unsigned ticks_taken = 0;
    int unsigned random_ticks = 0;
    int unsigned errors = 0;
    int unsigned cycle_cnt = 0;
    int unsigned gap_left = 0;
    int unsigned stall_left = 0;
    bit          no_idle = 1'b0;

    rainbow_bar_pattern_generator_top dut (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tlast  (m_axis_tlast),
        .m_axis_tuser  (m_axis_tuser),
        .i_cfg_valid   (i_cfg_valid),
        .o_cfg_ready   (o_cfg_ready),
        .i_cfg_index   (i_cfg_index),
        .i_cfg_data    (i_cfg_data)
    );

    always #1 i_clk = ~i_clk;

    function automatic int unsigned frame_dim(input logic [CFG_W-1:0] v);
        if (v == 0) return 1;
        if (v > MAX_DIM_DEF) return MAX_DIM_DEF;
        return 32'(v);
    endfunction

    function automatic logic [COLOR_W-1:0] band_hue(input int unsigned k, input int unsigned n);
        int unsigned d, s, t, up, down;
        if (n <= 1) return COLOR_RED;
        d = n - 1;
        if (k > d) k = d;
        s = (6 * k) / d;
        t = (6 * k) % d;
        up = (255 * t) / d;
        down = (255 * (d - t)) / d;
        case (t_sector'(s[2:0]))
            SEC_RED_YELLOW:   return {8'hFF, 8'(up), 8'h00};
            SEC_YELLOW_GREEN: return {8'(down), 8'hFF, 8'h00};
            SEC_GREEN_CYAN:   return {8'h00, 8'hFF, 8'(up)};
            SEC_CYAN_BLUE:    return {8'h00, 8'(down), 8'hFF};
            SEC_BLUE_MAGENTA: return {8'(up), 8'h00, 8'hFF};
            SEC_MAGENTA_RED:  return {8'hFF, 8'h00, 8'(down)};
            default:          return COLOR_RED;
        endcase
    endfunction

    // expected pixel for one accepted tick, then advance the raster
    function automatic void next_band_pixel(input logic restart);
        int unsigned w, h, segs;
        t_pixel px;
        if (restart) begin
            pos_x = 0;
            pos_y = 0;
        end
        if (pos_x == 0 && pos_y == 0) begin
            h = frame_dim(cfg_height);
            segs = (cfg_bands == 0) ? DEFAULT_BANDS : 32'(cfg_bands);
            if (segs > h) segs = h;
            rows_per_band = h / segs;
            band_total = (h + rows_per_band - 1) / rows_per_band;
            band_idx = 0;
            band_row = 0;
            band_rgb = band_hue(0, band_total);
        end
        w = frame_dim(cfg_width);
        h = frame_dim(cfg_height);
        px.pixel = cfg_rgb888 ? band_rgb
                              : {8'h00, band_rgb[23:19], band_rgb[15:10], band_rgb[7:3]};
        px.column = POS_W'(pos_x);
        px.row = POS_W'(pos_y);
        px.eor = (pos_x >= w - 1);
        px.eof = px.eor && (pos_y >= h - 1);
        pixels_due.push_back(px);
        if (!px.eor) begin
            pos_x++;
        end else begin
            pos_x = 0;
            if (px.eof) begin
                pos_y = 0;
            end else begin
                pos_y++;
                band_row++;
                if (band_row >= rows_per_band) begin
                    band_row = 0;
                    if (band_idx + 1 < band_total) begin
                        band_idx++;
                        band_rgb = band_hue(band_idx, band_total);
                    end
                end
            end
        end
    endfunction

    // mostly short, a few long
    function automatic int unsigned pick_gap();
        int unsigned r;
        r = $urandom_range(0, 99);
        if (no_idle || r < 55) return 0;
        if (r < 85) return $urandom_range(1, 3);
        if (r < 97) return $urandom_range(4, 9);
        return $urandom_range(15, 30);
    endfunction

    function automatic void check_field(input string name, input logic [COLOR_W-1:0] want,
                                        input logic [COLOR_W-1:0] got);
        if (want !== got) begin
            $display("%0t: %s mismatch, expected %h, actual %h", $time, name, want, got);
            errors++;
        end
    endfunction

    // input side
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            s_axis_tvalid <= 1'b0;
            gap_left = 0;
        end else begin
            if (s_axis_tvalid && s_axis_tready) begin
                next_band_pixel(s_axis_tdata[0]);
                ticks_taken++;
            end
            if (!s_axis_tvalid || s_axis_tready) begin
                if (gap_left > 0) begin
                    gap_left--;
                    s_axis_tvalid <= 1'b0;
                end else if (ticks_todo.size() > 0) begin
                    s_axis_tdata <= {7'b0, ticks_todo.pop_front()};
                    s_axis_tvalid <= 1'b1;
                    gap_left = pick_gap();
                end else begin
                    s_axis_tvalid <= 1'b0;
                end
            end
        end
    end

    // output side
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            m_axis_tready <= 1'b0;
            stall_left = 0;
        end else begin
            if (m_axis_tvalid && m_axis_tready) begin
                if (pixels_due.size() == 0) begin
                    $display("%0t: unexpected transfer, expected none, actual %h tlast %b tuser %b",
                             $time, m_axis_tdata, m_axis_tlast, m_axis_tuser);
                    errors++;
                end else begin
                    due = pixels_due.pop_front();
                    check_field("pixel", due.pixel, m_axis_tdata[23:0]);
                    check_field("column", COLOR_W'(due.column), COLOR_W'(m_axis_tdata[35:24]));
                    check_field("row", COLOR_W'(due.row), COLOR_W'(m_axis_tdata[47:36]));
                    check_field("end_of_row", COLOR_W'(due.eor), COLOR_W'(m_axis_tuser));
                    check_field("end_of_frame", COLOR_W'(due.eof), COLOR_W'(m_axis_tlast));
                end
            end
            if (stall_left > 0) begin
                stall_left--;
                m_axis_tready <= 1'b0;
            end else begin
                m_axis_tready <= 1'b1;
                if ($urandom_range(0, 3) == 0) stall_left = pick_gap();
            end
        end
    end

    always @(posedge i_clk) begin
        cycle_cnt++;
        if (cycle_cnt >= CYCLE_LIMIT) begin
            $display("Verification failed");
            $finish;
        end
    end

    task automatic send_tick(input logic restart);
        ticks_todo.push_back(restart);
        ticks_queued++;
    endtask

    // wait until every tick is taken and every pixel is back, then let band math finish
    task automatic settle();
        while (ticks_queued != ticks_taken || pixels_due.size() != 0) @(posedge i_clk);
        repeat (SETTLE_WAIT) @(posedge i_clk);
    endtask

    task automatic set_reg(input t_cfg_idx idx, input logic [CFG_W-1:0] val);
        i_cfg_valid <= 1'b1;
        i_cfg_index <= idx;
        i_cfg_data <= val;
        do @(posedge i_clk); while (!o_cfg_ready);
        case (idx)
            CFG_FRAME_WIDTH:  cfg_width = val;
            CFG_FRAME_HEIGHT: cfg_height = val;
            CFG_BAND_COUNT:   cfg_bands = val;
            CFG_COLOR_FORMAT: cfg_rgb888 = val[0];
            default:          ;
        endcase
    endtask

    task automatic set_frame(input logic [CFG_W-1:0] w, input logic [CFG_W-1:0] h,
                             input logic [CFG_W-1:0] bands, input logic rgb888);
        settle();
        set_reg(CFG_FRAME_WIDTH, w);
        set_reg(CFG_FRAME_HEIGHT, h);
        set_reg(CFG_BAND_COUNT, bands);
        set_reg(CFG_COLOR_FORMAT, CFG_W'(rgb888));
        i_cfg_valid <= 1'b0;
    endtask

    task automatic random_phase();
        int unsigned w, h, cap, n;
        settle();
        if ($urandom_range(0, 1)) begin
            set_reg(CFG_FRAME_WIDTH, ($urandom_range(0, 9) == 0) ? CFG_W'(0)
                                                                 : CFG_W'($urandom_range(1, 12)));
        end
        if ($urandom_range(0, 1)) begin
            set_reg(CFG_FRAME_HEIGHT, ($urandom_range(0, 9) == 0) ? CFG_W'(0)
                                                                  : CFG_W'($urandom_range(1, 40)));
        end
        if ($urandom_range(0, 1)) begin
            case ($urandom_range(0, 9))
                0:       set_reg(CFG_BAND_COUNT, CFG_W'(0));
                1:       set_reg(CFG_BAND_COUNT, CFG_W'(8191));
                default: set_reg(CFG_BAND_COUNT,
                                 CFG_W'($urandom_range(1, frame_dim(cfg_height) + 3)));
            endcase
        end
        if ($urandom_range(0, 2) == 0) set_reg(CFG_COLOR_FORMAT, CFG_W'($urandom_range(0, 1)));
        i_cfg_valid <= 1'b0;
        no_idle = ($urandom_range(0, 4) == 0);
        w = frame_dim(cfg_width);
        h = frame_dim(cfg_height);
        cap = w * h * 2 + 1;
        if (cap > 150) cap = 150;
        n = $urandom_range(1, cap);
        send_tick(1'($urandom_range(0, 1)));
        for (int unsigned i = 1; i < n; i++) send_tick($urandom_range(0, 39) == 0);
        random_ticks += n;
    endtask

    initial begin
        repeat (7) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // default frame after reset, then a restart
        send_tick(1'b0);
        send_tick(1'b0);
        send_tick(1'b1);
        // zero dimensions act as one pixel frames
        set_frame(13'd0, 13'd0, 13'd0, 1'b1);
        repeat (3) send_tick(1'b0);
        // single band, partway into a frame
        set_frame(13'd3, 13'd4, 13'd1, 1'b0);
        repeat (4) send_tick(1'b0);
        // width and height shrink mid frame
        set_frame(13'd1, 13'd2, 13'd1, 1'b0);
        repeat (2) send_tick(1'b0);
        set_frame(13'd1, 13'd2, 13'd2, 1'b1);
        send_tick(1'b1);
        // height grows mid frame, band index saturates
        set_frame(13'd1, 13'd6, 13'd2, 1'b1);
        repeat (5) send_tick(1'b0);
        // seven bands land on each sector boundary
        set_frame(13'd1, 13'd7, 13'd7, 1'b0);
        send_tick(1'b1);
        repeat (6) send_tick(1'b0);

        while (random_ticks < RANDOM_TICKS) random_phase();
        no_idle = 1'b0;

        // widest row
        set_frame(13'h1FFF, 13'd1, 13'd0, 1'b0);
        send_tick(1'b1);
        repeat (SCAN_TICKS) send_tick(1'b0);
        // tallest frame, one band per row
        set_frame(13'd1, 13'h1FFF, 13'h1FFF, 1'b1);
        send_tick(1'b1);
        repeat (SCAN_TICKS) send_tick(1'b0);

        settle();
        if (errors == 0) begin
            $display("Verification passed");
        end else begin
            $display("Verification failed");
        end
        $finish;
    end

endmodule

>>> sim.f
sv/rbpg_pkg.sv
sv/rbpg_div.sv
sv/rainbow_bar_pattern_generator_top.sv
sv/rbpg_checker.sv
tb/sv/tb_rainbow_bar_pattern_generator_top.sv
